>>> rtl/wkpq_pkg.sv
package wkpq_pkg;
  localparam int Capacity = 64;
  localparam int IdxW = $clog2(Capacity);
  localparam int CntW = $clog2(Capacity + 1);
  localparam logic [15:0] HalfOne = 16'd16384;
  localparam int QW = 15;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic CFG_MAX_GRADE = 1'b0;
  localparam logic CFG_TOTAL_COURSES = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_INSERT, S_REMOVE, S_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic insert;
    logic remove;
    logic out_load;
    logic [1:0] status;
  } cmd_t;

  typedef struct packed {
    logic is_deq;
    logic full;
    logic empty;
    logic div_done;
  } sts_t;
endpackage

>>> rtl/wkpq_datapath.sv
module wkpq_datapath (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [11:0] cfg_wdata,
  input  logic in_func,
  input  logic [31:0] in_elem,
  input  logic [11:0] in_grade,
  input  logic [7:0] in_courses,
  input  wkpq_pkg::cmd_t cmd,
  output wkpq_pkg::sts_t sts,
  output logic [31:0] o_elem,
  output logic [11:0] o_grade,
  output logic [7:0] o_courses,
  output logic [15:0] o_key,
  output logic [6:0] o_count,
  output logic [1:0] o_status
);
  import wkpq_pkg::*;

  logic [11:0] maxg_r;
  logic [7:0] totc_r;
  logic func_r;
  logic [31:0] elem_r;
  logic [11:0] grade_r;
  logic [7:0] courses_r;
  // Two restoring dividers, one quotient bit per cycle.
  logic [26:0] rg_r;
  logic [22:0] rc_r;
  logic [QW-1:0] qg_r, qc_r;
  logic [3:0] bit_r;
  logic [CntW-1:0] cnt_r;
  logic [31:0] e_elem_r [Capacity];
  logic [11:0] e_grade_r [Capacity];
  logic [7:0] e_courses_r [Capacity];
  logic [15:0] e_key_r [Capacity];

  logic [26:0] rg_sh;
  logic [22:0] rc_sh;
  logic [15:0] tg, tc, key;
  logic [Capacity-1:0] le;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      maxg_r <= 12'd2560;
      totc_r <= 8'd40;
    end else if (cfg_we) begin
      if (cfg_index == CFG_MAX_GRADE) maxg_r <= cfg_wdata;
      else totc_r <= cfg_wdata[7:0];
    end
  end

  always_comb begin
    rg_sh = {rg_r[25:0], 1'b0};
    rc_sh = {rc_r[21:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_func;
      elem_r <= in_elem;
      grade_r <= in_grade;
      courses_r <= in_courses;
      // The first shift moves the numerator into the remainder field, so the
      // first step yields the 2^14 quotient bit of num*2^14/den.
      rg_r <= {2'd0, in_grade, 13'd0};
      rc_r <= {2'd0, in_courses, 13'd0};
      qg_r <= '0;
      qc_r <= '0;
      bit_r <= 4'd0;
    end else if (cmd.div_step) begin
      // Dividend num*2^14: the remainder doubles each step with a zero shifted in.
      if (rg_sh[26:14] >= {1'b0, maxg_r}) begin
        rg_r <= {rg_sh[26:14] - {1'b0, maxg_r}, rg_sh[13:0]};
        qg_r <= {qg_r[QW-2:0], 1'b1};
      end else begin
        rg_r <= rg_sh;
        qg_r <= {qg_r[QW-2:0], 1'b0};
      end
      if (rc_sh[22:14] >= {1'b0, totc_r}) begin
        rc_r <= {rc_sh[22:14] - {1'b0, totc_r}, rc_sh[13:0]};
        qc_r <= {qc_r[QW-2:0], 1'b1};
      end else begin
        rc_r <= rc_sh;
        qc_r <= {qc_r[QW-2:0], 1'b0};
      end
      bit_r <= bit_r + 4'd1;
    end
  end

  always_comb begin
    // A numerator above its divisor, or a zero divisor, saturates the term;
    // otherwise the quotient is at most 2^14 and fits the 15 bits.
    tg = (maxg_r == 12'd0 || grade_r > maxg_r) ? HalfOne : {1'b0, qg_r};
    tc = (totc_r == 8'd0 || courses_r > totc_r) ? HalfOne : {1'b0, qc_r};
    key = tg + tc;
    for (int i = 0; i < Capacity; i++)
      le[i] = (CntW'(i) < cnt_r) && (e_key_r[i] <= key);
  end

  // Shift register cells: insert after all keys not above the new one.
  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      if (!le[0]) begin
        e_elem_r[0] <= elem_r;
        e_grade_r[0] <= grade_r;
        e_courses_r[0] <= courses_r;
        e_key_r[0] <= key;
      end
      for (int i = 1; i < Capacity; i++) begin
        if (!le[i]) begin
          if (le[i-1]) begin
            e_elem_r[i] <= elem_r;
            e_grade_r[i] <= grade_r;
            e_courses_r[i] <= courses_r;
            e_key_r[i] <= key;
          end else begin
            e_elem_r[i] <= e_elem_r[i-1];
            e_grade_r[i] <= e_grade_r[i-1];
            e_courses_r[i] <= e_courses_r[i-1];
            e_key_r[i] <= e_key_r[i-1];
          end
        end
      end
    end else if (cmd.remove) begin
      for (int i = 0; i < Capacity - 1; i++) begin
        e_elem_r[i] <= e_elem_r[i+1];
        e_grade_r[i] <= e_grade_r[i+1];
        e_courses_r[i] <= e_courses_r[i+1];
        e_key_r[i] <= e_key_r[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= '0;
    else if (cmd.insert) cnt_r <= cnt_r + CntW'(1);
    else if (cmd.remove) cnt_r <= cnt_r - CntW'(1);
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      o_status <= cmd.status;
      o_count <= 7'(cnt_r);
      if (cnt_r != '0) begin
        o_elem <= e_elem_r[0];
        o_grade <= e_grade_r[0];
        o_courses <= e_courses_r[0];
        o_key <= e_key_r[0];
      end else begin
        o_elem <= '0;
        o_grade <= '0;
        o_courses <= '0;
        o_key <= '0;
      end
    end
  end

  always_comb begin
    sts.is_deq = func_r;
    sts.full = (cnt_r == CntW'(Capacity));
    sts.empty = (cnt_r == '0);
    sts.div_done = (bit_r == 4'(QW - 1));
  end

  always_ff @(posedge clk) begin
    if (rst_n) begin
      assert (cnt_r <= CntW'(Capacity)) else $error("count above capacity");
    end
  end
  a_ins_nofull: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.insert |-> !sts.full) else $error("insert into full queue");
  a_rem_noempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.remove |-> !sts.empty) else $error("remove from empty queue");
  a_ins_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.insert |=> cnt_r == $past(cnt_r) + CntW'(1)) else $error("count slip");
endmodule

>>> rtl/wkpq_ctrl.sv
module wkpq_ctrl (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  output logic out_tvalid,
  input  logic out_tready,
  input  wkpq_pkg::sts_t sts,
  output wkpq_pkg::cmd_t cmd
);
  import wkpq_pkg::*;

  state_t state_r, state_nxt;
  logic ov_r, ov_nxt;
  logic [1:0] st_r, st_nxt;

  always_comb begin
    state_nxt = state_r;
    st_nxt = st_r;
    unique case (state_r)
      S_IDLE: if (in_tvalid && in_tready) state_nxt = S_DIV;
      S_DIV: begin
        if (sts.is_deq) begin
          state_nxt = sts.empty ? S_OUT : S_REMOVE;
          st_nxt = sts.empty ? ST_EMPTY : ST_OK;
        end else if (sts.full) begin
          state_nxt = S_OUT;
          st_nxt = ST_FULL;
        end else if (sts.div_done) begin
          state_nxt = S_INSERT;
          st_nxt = ST_OK;
        end
      end
      S_INSERT: state_nxt = S_OUT;
      S_REMOVE: state_nxt = S_OUT;
      S_OUT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.status = st_r;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = !ov_r || out_tready;
        cmd.load = in_tvalid && in_tready;
      end
      S_DIV: cmd.div_step = 1'b1;
      S_INSERT: cmd.insert = 1'b1;
      S_REMOVE: cmd.remove = 1'b1;
      S_OUT: cmd.out_load = 1'b1;
      default: ;
    endcase
    ov_nxt = ov_r;
    if (out_tready) ov_nxt = 1'b0;
    if (cmd.out_load) ov_nxt = 1'b1;
  end

  assign out_tvalid = ov_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r <= 1'b0;
      st_r <= ST_OK;
    end else begin
      state_r <= state_nxt;
      ov_r <= ov_nxt;
      st_r <= st_nxt;
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> state_r == S_IDLE) else $error("ready outside idle");
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !ov_r) else $error("result overwritten");
  a_load_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == S_DIV) else $error("load lost");
endmodule

>>> rtl/weighted_key_priority_queue_top.sv
// Sorted-list priority queue keyed by a weighted grade/course score.
// Input beats (in_*) carry an operation: func 0 enqueues elem with its
// grade and course count, func 1 dequeues the front entry. Each accepted
// beat yields exactly one output beat (out_*) showing the front entry after
// the operation, the entry count and a status (ok, full, empty).
// The key is the sum of two saturating 15-bit quotients computed by a pair
// of restoring dividers, one quotient bit per cycle. An enqueue passes
// through the divide, insert and output states to the result register; a
// dequeue leaves the divide state at once for remove and output, and a
// rejected operation (full enqueue, empty dequeue) skips to output.
// Insertion is done in a row of shift cells. One operation is in flight
// at a time; the next beat is accepted in the cycle after the result is
// loaded, while that result may still wait in the output register.
// If the receiver stalls, the result holds and no new beat is accepted
// until out_tready frees the output register.
// Reset (rst_n low, synchronous) empties the queue and restores the
// divisor registers to 2560 and 40. cfg_* writes take effect at once and
// must be issued only while the block is idle.
module weighted_key_priority_queue_top (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [11:0] cfg_wdata,
  input  logic in_tvalid,
  output logic in_tready,
  input  logic in_tuser,           // func
  input  logic [55:0] in_tdata,    // elem[31:0], grade[43:32], courses[51:44], zero pad
  output logic out_tvalid,
  input  logic out_tready,
  output logic [79:0] out_tdata    // front_elem, front_grade, front_courses,
                                   // front_key, count, status, zero pad
);
  import wkpq_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic [31:0] o_elem;
  logic [11:0] o_grade;
  logic [7:0] o_courses;
  logic [15:0] o_key;
  logic [6:0] o_count;
  logic [1:0] o_status;

  wkpq_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready,
    .sts, .cmd
  );

  wkpq_datapath u_dp (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata,
    .in_func(in_tuser), .in_elem(in_tdata[31:0]), .in_grade(in_tdata[43:32]),
    .in_courses(in_tdata[51:44]), .cmd, .sts,
    .o_elem, .o_grade, .o_courses, .o_key, .o_count, .o_status
  );

  assign out_tdata = {3'd0, o_status, o_count, o_key, o_courses, o_grade, o_elem};
endmodule
